[hdl/afd_pkg.sv]
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the serial API frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam logic [2:0]  PH_WAIT    = 3'd0;
    localparam logic [2:0]  PH_MSB     = 3'd1;
    localparam logic [2:0]  PH_LSB     = 3'd2;
    localparam logic [2:0]  PH_DATA    = 3'd3;
    localparam logic [2:0]  PH_CHK     = 3'd4;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  SUM_INIT   = 8'hFF;
    localparam logic [15:0] MIN_LEN    = 16'd2;
    localparam logic [15:0] MAX_LEN_RST = 16'd255;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_rx;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic        frame_good;
        logic [15:0] frame_length;
        logic        length_rejected;
    } t_result;

endpackage

[hdl/afd_in_reg.sv]
// ----------------------------------------------------------------------------
// afd_in_reg
// Input register holding one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module afd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  afd_pkg::t_rx  i_rx,
    input  logic          i_adv,
    output logic          o_valid,
    output afd_pkg::t_rx  o_rx
);

    logic         r_valid;
    logic         n_valid;
    afd_pkg::t_rx r_rx;
    logic         w_load;

    assign o_stall = r_valid & ~i_adv;
    assign w_load  = i_valid & ~o_stall;
    assign n_valid = w_load | (r_valid & ~i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rx <= i_rx;
        end
    end

    assign o_valid = r_valid;
    assign o_rx    = r_rx;

endmodule

[hdl/afd_parser.sv]
// ----------------------------------------------------------------------------
// afd_parser
// Frame parser state and the per-byte result logic.
// ----------------------------------------------------------------------------
module afd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_adv,
    input  afd_pkg::t_rx      i_rx,
    output afd_pkg::t_result  o_res
);

    logic [15:0] r_max_len;
    logic [2:0]  r_phase;
    logic [2:0]  n_phase;
    logic [15:0] r_len;
    logic [15:0] n_len;
    logic [15:0] r_seen;
    logic [15:0] n_seen;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic [15:0] w_seen_inc;
    logic [15:0] w_lsb_len;
    logic [7:0]  w_sum_sub;
    logic        w_is_start;

    assign w_seen_inc = r_seen + 16'd1;
    assign w_lsb_len  = {r_len[15:8], i_rx.rx_byte};
    assign w_sum_sub  = r_sum - i_rx.rx_byte;
    assign w_is_start = (i_rx.rx_byte == afd_pkg::START_BYTE);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        n_sum   = r_sum;
        o_res   = '0;
        if (!i_rx.rx_error) begin
            unique case (r_phase)
                afd_pkg::PH_MSB: begin
                    if (!w_is_start) begin
                        n_len   = {i_rx.rx_byte, 8'h00};
                        n_phase = afd_pkg::PH_LSB;
                    end
                end
                afd_pkg::PH_LSB: begin
                    n_len = w_lsb_len;
                    if (w_lsb_len > r_max_len || w_lsb_len < afd_pkg::MIN_LEN) begin
                        o_res.length_rejected = 1'b1;
                        n_phase = w_is_start ? afd_pkg::PH_MSB : afd_pkg::PH_WAIT;
                    end else begin
                        n_phase = afd_pkg::PH_DATA;
                        n_seen  = '0;
                        n_sum   = afd_pkg::SUM_INIT;
                    end
                end
                afd_pkg::PH_DATA: begin
                    o_res.payload_valid = 1'b1;
                    o_res.payload_byte  = i_rx.rx_byte;
                    o_res.payload_index = r_seen;
                    n_sum  = w_sum_sub;
                    n_seen = w_seen_inc;
                    if (w_seen_inc == r_len) begin
                        n_phase = afd_pkg::PH_CHK;
                    end
                end
                afd_pkg::PH_CHK: begin
                    n_sum            = w_sum_sub;
                    o_res.frame_done = 1'b1;
                    o_res.frame_good = (w_sum_sub == 8'h00);
                    n_phase          = afd_pkg::PH_WAIT;
                end
                default: begin
                    n_phase = w_is_start ? afd_pkg::PH_MSB : afd_pkg::PH_WAIT;
                end
            endcase
        end
        o_res.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= afd_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= afd_pkg::PH_WAIT;
            r_len   <= '0;
            r_seen  <= '0;
            r_sum   <= afd_pkg::SUM_INIT;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    // A finished frame always returns the parser to hunting for a start byte.
    a_done_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res.frame_done |=> r_phase == afd_pkg::PH_WAIT)
        else $error("parser did not return to hunting after a frame");

    // Inside a frame the count stays below the declared length of at least two.
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == afd_pkg::PH_DATA |-> (r_len >= afd_pkg::MIN_LEN) && (r_seen < r_len))
        else $error("data phase entered with inconsistent length or count");

    // Nothing is streamed or verified while a state update is withheld.
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_seen) && $stable(r_sum))
        else $error("parser state changed without a request");

endmodule

[hdl/afd_out_reg.sv]
// ----------------------------------------------------------------------------
// afd_out_reg
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module afd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  afd_pkg::t_result  i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output afd_pkg::t_result  o_res
);

    logic             r_valid;
    logic             n_valid;
    afd_pkg::t_result r_res;

    assign o_free  = ~r_valid | ~i_stall;
    assign n_valid = i_load | (r_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A held result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |-> !i_load)
        else $error("result register loaded while its result was held");

    // A load always leaves a result on show in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

    // The register only empties when its result was taken.
    a_empty_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_load && !i_stall |=> !r_valid)
        else $error("result register failed to empty after a request");

endmodule

[hdl/api_frame_deframer.sv]
// ----------------------------------------------------------------------------
// api_frame_deframer
// Streaming deframer for API-mode serial frames with checksum verdict.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  input    | i_in_valid / o_in_stall    | i_rx_byte, i_rx_error
//  output   | o_out_valid / i_out_stall  | o_payload_*, o_frame_*,
//           |                            | o_length_rejected
//  config   | i_cfg_we                   | i_cfg_wdata (max_frame_len)
//
//  One request is accepted every cycle while the output is not stalled; each
//  gives exactly one result. A request waits in the input register; its result
//  is then held in the result register. The rate is set by the combinational
//  parser update between the input register and the result register.
//  Reset is synchronous and active low; max_frame_len returns to 255.
//  A stall on the output holds the result and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module api_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_error,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic        o_frame_done,
    output logic        o_frame_good,
    output logic [15:0] o_frame_length,
    output logic        o_length_rejected
);

    afd_pkg::t_rx     w_rx_in;
    afd_pkg::t_rx     w_rx;
    afd_pkg::t_result w_res;
    afd_pkg::t_result w_out;
    logic             w_rx_valid;
    logic             w_free;
    logic             w_adv;

    assign w_rx_in.rx_byte  = i_rx_byte;
    assign w_rx_in.rx_error = i_rx_error;
    assign w_adv            = w_rx_valid & w_free;

    afd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_rx    (w_rx_in),
        .i_adv   (w_adv),
        .o_valid (w_rx_valid),
        .o_rx    (w_rx)
    );

    afd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (w_adv),
        .i_rx        (w_rx),
        .o_res       (w_res)
    );

    afd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out)
    );

    assign o_payload_valid   = w_out.payload_valid;
    assign o_payload_byte    = w_out.payload_byte;
    assign o_payload_index   = w_out.payload_index;
    assign o_frame_done      = w_out.frame_done;
    assign o_frame_good      = w_out.frame_good;
    assign o_frame_length    = w_out.frame_length;
    assign o_length_rejected = w_out.length_rejected;

endmodule

[verif/deframer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the request, result and configuration ports of the frame deframer,
// predicts every result from the accepted requests and compares the two.
// ----------------------------------------------------------------------------
module deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_error,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_payload_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_payload_index,
    input  logic        i_frame_done,
    input  logic        i_frame_good,
    input  logic [15:0] i_frame_length,
    input  logic        i_length_rejected,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_frames_good,
    output int          o_frames_bad,
    output int          o_rejects
);

    logic [15:0]      max_len = afd_pkg::MAX_LEN_RST;
    logic [2:0]       phase = afd_pkg::PH_WAIT;
    logic [15:0]      frame_len = '0;
    logic [15:0]      data_count = '0;
    logic [7:0]       csum = afd_pkg::SUM_INIT;
    afd_pkg::t_result pending_results[$];
    int               errors = 0;
    int               results = 0;
    int               frames_good = 0;
    int               frames_bad = 0;
    int               rejects = 0;

    task automatic parse_byte(input logic [7:0] b, input logic err,
                              output afd_pkg::t_result r);
        r = '0;
        if (!err) begin
            case (phase)
                afd_pkg::PH_MSB: begin
                    if (b != afd_pkg::START_BYTE) begin
                        frame_len = {b, 8'h00};
                        phase = afd_pkg::PH_LSB;
                    end
                end
                afd_pkg::PH_LSB: begin
                    frame_len = {frame_len[15:8], b};
                    if (frame_len > max_len || frame_len < afd_pkg::MIN_LEN) begin
                        r.length_rejected = 1'b1;
                        phase = (b == afd_pkg::START_BYTE) ? afd_pkg::PH_MSB
                                                           : afd_pkg::PH_WAIT;
                    end else begin
                        phase = afd_pkg::PH_DATA;
                        data_count = '0;
                        csum = afd_pkg::SUM_INIT;
                    end
                end
                afd_pkg::PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    r.payload_index = data_count;
                    csum = csum - b;
                    data_count = data_count + 16'd1;
                    if (data_count == frame_len) begin
                        phase = afd_pkg::PH_CHK;
                    end
                end
                afd_pkg::PH_CHK: begin
                    csum = csum - b;
                    r.frame_done = 1'b1;
                    r.frame_good = (csum == 8'h00);
                    phase = afd_pkg::PH_WAIT;
                end
                default: begin
                    phase = (b == afd_pkg::START_BYTE) ? afd_pkg::PH_MSB
                                                       : afd_pkg::PH_WAIT;
                end
            endcase
        end
        r.frame_length = frame_len;
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        afd_pkg::t_result fresh;
        afd_pkg::t_result want;
        if (!i_rst_n) begin
            max_len = afd_pkg::MAX_LEN_RST;
            phase = afd_pkg::PH_WAIT;
            frame_len = '0;
            data_count = '0;
            csum = afd_pkg::SUM_INIT;
            pending_results.delete();
            errors = 0;
            results = 0;
            frames_good = 0;
            frames_bad = 0;
            rejects = 0;
        end else begin
            if (i_cfg_we) begin
                max_len = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_rx_byte, i_rx_error, fresh);
                pending_results.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result arrived with no request outstanding", $time);
                end else begin
                    want = pending_results.pop_front();
                    check_field("payload_valid", 16'(want.payload_valid),
                                16'(i_payload_valid));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(i_payload_byte));
                    check_field("payload_index", want.payload_index, i_payload_index);
                    check_field("frame_done", 16'(want.frame_done), 16'(i_frame_done));
                    check_field("frame_good", 16'(want.frame_good), 16'(i_frame_good));
                    check_field("frame_length", want.frame_length, i_frame_length);
                    check_field("length_rejected", 16'(want.length_rejected),
                                16'(i_length_rejected));
                    results++;
                    if (want.frame_done && want.frame_good) begin
                        frames_good++;
                    end
                    if (want.frame_done && !want.frame_good) begin
                        frames_bad++;
                    end
                    if (want.length_rejected) begin
                        rejects++;
                    end
                end
            end
        end
        o_errors <= errors;
        o_pending <= pending_results.size();
        o_results <= results;
        o_frames_good <= frames_good;
        o_frames_bad <= frames_bad;
        o_rejects <= rejects;
    end

endmodule

[verif/api_frame_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_deframer_test
// Drives serial bytes into the frame deframer: a short directed opening, then
// random frames, broken headers and line noise over several maximum lengths,
// with bursty requests and a stalling receiver. The checker gives the verdict.
// ----------------------------------------------------------------------------
module api_frame_deframer_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        rx_error = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        frame_good;
    logic [15:0] frame_length;
    logic        length_rejected;

    int errors;
    int pending;
    int results;
    int frames_good;
    int frames_bad;
    int rejects;

    int          burst_left = 0;
    int          max_gap = 2;
    int          stall_pct = 20;
    int          stall_run = 0;
    int          err_pct = 0;
    int          sent = 0;
    logic [15:0] cur_max = afd_pkg::MAX_LEN_RST;
    int          stall_plan [6] = '{0, 30, 60, 20, 80, 10};
    int          gap_plan [6] = '{0, 3, 8, 1, 5, 2};
    logic [15:0] max_plan [6];

    // Bit 8 marks a byte flagged with a line error.
    logic [8:0] opening [27] = '{
        9'h17E, 9'h055, 9'h07E, 9'h000, 9'h002, 9'h000, 9'h0FF, 9'h000,
        9'h07E, 9'h07E, 9'h000, 9'h001,
        9'h07E, 9'h001, 9'h07E, 9'h000, 9'h000,
        9'h07E, 9'h000, 9'h002, 9'h0AB, 9'h1FF, 9'h0CD, 9'h086,
        9'h07E, 9'h0FF, 9'h0FF
    };

    api_frame_deframer uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (rx_valid),
        .o_in_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .i_rx_error       (rx_error),
        .o_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .o_payload_valid  (payload_valid),
        .o_payload_byte   (payload_byte),
        .o_payload_index  (payload_index),
        .o_frame_done     (frame_done),
        .o_frame_good     (frame_good),
        .o_frame_length   (frame_length),
        .o_length_rejected(length_rejected)
    );

    deframer_checker deframe_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (rx_valid),
        .i_in_stall       (rx_stall),
        .i_rx_byte        (rx_byte),
        .i_rx_error       (rx_error),
        .i_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .i_payload_valid  (payload_valid),
        .i_payload_byte   (payload_byte),
        .i_payload_index  (payload_index),
        .i_frame_done     (frame_done),
        .i_frame_good     (frame_good),
        .i_frame_length   (frame_length),
        .i_length_rejected(length_rejected),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_results        (results),
        .o_frames_good    (frames_good),
        .o_frames_bad     (frames_bad),
        .o_rejects        (rejects)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (stall_run == 0) begin
            res_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, 8);
        end else begin
            stall_run--;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            repeat (gap) begin
                @(negedge clk);
                rx_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte <= b;
        rx_error <= e;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        if (!e) begin
            sent++;
        end
    endtask

    task automatic send_clean(input logic [7:0] b);
        if ($urandom_range(0, 99) < err_pct) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        send_byte(b, 1'b0);
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good);
        logic [7:0] sum;
        logic [7:0] d;
        sum = afd_pkg::SUM_INIT;
        if ($urandom_range(0, 7) == 0) begin
            send_clean(afd_pkg::START_BYTE);
        end
        send_clean(afd_pkg::START_BYTE);
        send_clean(len[15:8]);
        send_clean(len[7:0]);
        for (int k = 0; k < len; k++) begin
            d = 8'($urandom_range(0, 255));
            sum = sum - d;
            send_clean(d);
        end
        if (!good) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_clean(sum);
    endtask

    task automatic send_bad_length();
        logic [15:0] len;
        case ($urandom_range(0, 2))
            0: begin
                len = 16'($urandom_range(0, 1));
            end
            1: begin
                len = (cur_max == 16'hFFFF) ? 16'h0000 : 16'($urandom_range(cur_max + 1, 65535));
            end
            default: begin
                len = (cur_max < 16'h7F7E)
                    ? {8'($urandom_range(8'h7F, 8'hFF)), afd_pkg::START_BYTE}
                    : 16'h0001;
            end
        endcase
        send_clean(afd_pkg::START_BYTE);
        send_clean(len[15:8]);
        send_clean(len[7:0]);
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (cur_max < 16'h0100 && $urandom_range(0, 3) == 0) begin
                b = afd_pkg::START_BYTE;
            end else if (cur_max >= 16'h0100 && b == afd_pkg::START_BYTE) begin
                b = 8'h7F;
            end
            send_clean(b);
        end
    endtask

    task automatic send_random_chunk();
        int roll;
        int hi;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            hi = (cur_max < 2) ? 8 : ((cur_max > 16) ? 16 : cur_max);
            if (cur_max >= 2 && $urandom_range(0, 9) == 0) begin
                hi = (cur_max > 64) ? 64 : cur_max;
            end
            send_frame(16'($urandom_range(2, hi)), $urandom_range(0, 4) != 0);
        end else if (roll < 85) begin
            send_bad_length();
        end else begin
            send_noise();
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_max(input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_max = value;
        burst_left = 0;
    endtask

    initial begin
        int target;
        max_plan = '{16'd255, 16'd2, 16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(3, 40))};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[k]) begin
            send_byte(opening[k][7:0], opening[k][8]);
        end

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            set_max(max_plan[p]);
            stall_pct = stall_plan[p];
            max_gap = gap_plan[p];
            err_pct = (p % 3) * 4;
            target = sent + 180;
            while (sent < target) send_random_chunk();
        end

        // A frame of the largest declared length opens the data phase at the very end.
        wait_idle();
        set_max(16'hFFFF);
        stall_pct = 40;
        max_gap = 3;
        send_byte(afd_pkg::START_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();

        $display("Sent %0d bytes under maximum lengths 255, 2, 65535, 0, 1 and %0d.",
                 sent, max_plan[5]);
        $display("Checked %0d results: %0d good frames, %0d bad frames, %0d rejected lengths.",
                 results, frames_good, frames_bad, rejects);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
